// ===== src/font_text_to_page_framebuffer_defines.svh =====
// ----------------------------------------------------------------------------
// Font text to page framebuffer: assertion macros
// Shared assertion forms for the character generator. They expand to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FONT_TEXT_TO_PAGE_FRAMEBUFFER_DEFINES_SVH
`define FONT_TEXT_TO_PAGE_FRAMEBUFFER_DEFINES_SVH

`ifndef SYNTHESIS
`define FTTP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fttp: same-cycle check failed");
`define FTTP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fttp: next-cycle check failed");
`else
`define FTTP_ASSERT_SAME(lbl, ante, cons)
`define FTTP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/fttp_pkg.sv =====
// ----------------------------------------------------------------------------
// Font text to page framebuffer package
// Geometry, display command codes and the command and status groups that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package fttp_pkg;

    localparam int COLUMNS     = 128;
    localparam int FONT_DEPTH  = 4096;
    localparam int GLYPH_BYTES = 25;
    localparam int GLYPH_COLS  = 12;
    localparam int FIRST_CODE  = 32;
    localparam int PAGES       = 4;

    localparam int FRAME_BYTES = PAGES * COLUMNS;
    localparam int FRAME_AW    = $clog2(FRAME_BYTES);
    localparam int FONT_AW     = $clog2(FONT_DEPTH);
    localparam int BASE_W      = $clog2(FONT_DEPTH + 256 * GLYPH_BYTES + 1);
    localparam int POS_W       = $clog2(COLUMNS + 3);
    localparam int STEP_W      = $clog2(GLYPH_BYTES + 1);
    localparam int COL_W       = 9;
    localparam int CALC_W      = FRAME_AW + COL_W;

    localparam logic [7:0] CMD_COL_LO = 8'h00;
    localparam logic [7:0] CMD_COL_HI = 8'h10;
    localparam logic [7:0] CMD_PAGE   = 8'hB0;

    typedef logic [FRAME_AW-1:0] t_frame_addr;
    typedef logic [FONT_AW-1:0]  t_font_addr;
    typedef logic [BASE_W-1:0]   t_base;
    typedef logic [POS_W-1:0]    t_pos;
    typedef logic [STEP_W-1:0]   t_step;
    typedef logic [COL_W-1:0]    t_col;
    typedef logic [CALC_W-1:0]   t_calc;

    typedef enum logic [1:0] {
        KIND_FONT_WR = 2'd0,
        KIND_RENDER  = 2'd1,
        KIND_PULL    = 2'd2,
        KIND_CLEAR   = 2'd3
    } t_kind;

    typedef struct packed {
        logic font_wr;
        logic render_setup;
        logic render_step;
        logic pull_rd;
        logic pull_out;
        logic clear_start;
        logic clear_step;
    } t_cmd;

    typedef struct packed {
        logic glyph_ok;
        logic render_done;
        logic clear_done;
        logic fl_last;
        logic out_free;
    } t_sts;

endpackage

// ===== src/fttp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Font text to page framebuffer controller
// Sequences font writes, glyph rendering, flush pulls and the frame clearing
// pass, and drives the input stall.
// ----------------------------------------------------------------------------
module fttp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_kind,
    output logic             o_in_stall,
    input  fttp_pkg::t_sts   i_sts,
    output fttp_pkg::t_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RENDER,
        S_PULL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    case (fttp_pkg::t_kind'(i_kind))
                        fttp_pkg::KIND_FONT_WR: begin
                            o_cmd.font_wr = 1'b1;
                        end
                        fttp_pkg::KIND_RENDER: begin
                            o_cmd.render_setup = 1'b1;
                            if (i_sts.glyph_ok) begin
                                n_state = S_RENDER;
                            end
                        end
                        fttp_pkg::KIND_PULL: begin
                            o_cmd.pull_rd = 1'b1;
                            n_state       = S_PULL;
                        end
                        fttp_pkg::KIND_CLEAR: begin
                            o_cmd.clear_start = 1'b1;
                            n_state           = S_CLEAR;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RENDER: begin
                o_cmd.render_step = 1'b1;
                if (i_sts.render_done) begin
                    n_state = S_IDLE;
                end
            end
            S_PULL: begin
                if (i_sts.out_free) begin
                    o_cmd.pull_out = 1'b1;
                    if (i_sts.fl_last) begin
                        o_cmd.clear_start = 1'b1;
                        n_state           = S_CLEAR;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_in_stall <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_stall <= (n_state != S_IDLE);
        end
    end

    assign o_in_stall = r_in_stall;

endmodule

// ===== src/fttp_datapath.sv =====
// ----------------------------------------------------------------------------
// Font text to page framebuffer datapath
// Font store, frame store, text cursors, flush position, clearing counter and
// the output register.
// ----------------------------------------------------------------------------
module fttp_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fttp_pkg::t_cmd   i_cmd,
    output fttp_pkg::t_sts   o_sts,
    input  logic [11:0]      i_font_addr,
    input  logic [7:0]       i_font_byte,
    input  logic [7:0]       i_char_code,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output logic [7:0]       o_out_byte,
    output logic             o_is_data,
    output logic             o_frame_last
);

    logic [7:0] r_font_mem [fttp_pkg::FONT_DEPTH];
    logic [7:0] r_frame_mem [fttp_pkg::FRAME_BYTES];
    logic [7:0] r_font_rd;
    logic [7:0] r_frame_rd;

    logic [7:0]              r_top_cur;
    logic [7:0]              r_bot_cur;
    logic [7:0]              r_cur;
    logic                    r_line_bot;
    fttp_pkg::t_base         r_base;
    fttp_pkg::t_step         r_step;
    fttp_pkg::t_frame_addr   r_clr_addr;
    logic [1:0]              r_fl_page;
    fttp_pkg::t_pos          r_fl_pos;
    logic                    r_out_valid;
    logic [7:0]              r_out_byte;
    logic                    r_out_is_data;
    logic                    r_out_last;

    logic [7:0]              w_glyph;
    fttp_pkg::t_base         w_base;
    logic                    w_glyph_ok;
    logic                    w_top;
    logic                    w_faddr_ok;
    fttp_pkg::t_step         w_data_idx;
    logic [3:0]              w_k;
    fttp_pkg::t_col          w_col;
    logic [1:0]              w_wr_page;
    logic                    w_render_wr;
    fttp_pkg::t_calc         w_render_addr;
    fttp_pkg::t_calc         w_pull_addr;
    fttp_pkg::t_frame_addr   w_fr_addr;
    logic [7:0]              w_fr_wdata;
    logic                    w_fr_we;
    logic [8:0]              w_adv_sum;
    logic [7:0]              w_adv;
    logic                    w_pos_end;
    logic                    w_fl_last;
    logic                    w_out_free;
    logic [7:0]              w_pull_byte;
    logic                    w_pull_data;

    assign w_glyph    = i_char_code - 8'(fttp_pkg::FIRST_CODE);
    assign w_base     = fttp_pkg::t_base'(w_glyph) * fttp_pkg::t_base'(fttp_pkg::GLYPH_BYTES);
    assign w_glyph_ok = (i_char_code >= 8'(fttp_pkg::FIRST_CODE)) &&
                        ((w_base + fttp_pkg::t_base'(fttp_pkg::GLYPH_BYTES)) <=
                         fttp_pkg::t_base'(fttp_pkg::FONT_DEPTH));
    assign w_top      = (fttp_pkg::t_col'(r_top_cur) + fttp_pkg::t_col'(fttp_pkg::GLYPH_COLS)) <
                        fttp_pkg::t_col'(fttp_pkg::COLUMNS);
    assign w_faddr_ok = fttp_pkg::t_base'(i_font_addr) < fttp_pkg::t_base'(fttp_pkg::FONT_DEPTH);

    assign w_data_idx  = r_step - fttp_pkg::t_step'(2);
    assign w_k         = w_data_idx[4:1];
    assign w_col       = fttp_pkg::t_col'(r_cur) + fttp_pkg::t_col'(w_k);
    assign w_wr_page   = {r_line_bot, w_data_idx[0]};
    assign w_render_wr = i_cmd.render_step && (r_step >= fttp_pkg::t_step'(2)) &&
                         (w_col < fttp_pkg::t_col'(fttp_pkg::COLUMNS));
    assign w_render_addr = fttp_pkg::t_calc'(w_wr_page) * fttp_pkg::t_calc'(fttp_pkg::COLUMNS) +
                           fttp_pkg::t_calc'(w_col);
    assign w_pull_addr   = fttp_pkg::t_calc'(r_fl_page) * fttp_pkg::t_calc'(fttp_pkg::COLUMNS) +
                           fttp_pkg::t_calc'(r_fl_pos) - fttp_pkg::t_calc'(3);

    always_comb begin
        w_fr_addr  = fttp_pkg::t_frame_addr'(w_pull_addr);
        w_fr_wdata = r_font_rd;
        w_fr_we    = 1'b0;
        if (i_cmd.clear_step) begin
            w_fr_addr  = r_clr_addr;
            w_fr_wdata = 8'h00;
            w_fr_we    = 1'b1;
        end else if (i_cmd.render_step) begin
            w_fr_addr = fttp_pkg::t_frame_addr'(w_render_addr);
            w_fr_we   = w_render_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.font_wr && w_faddr_ok) begin
            r_font_mem[fttp_pkg::t_font_addr'(i_font_addr)] <= i_font_byte;
        end
        if (i_cmd.render_step && (r_step < fttp_pkg::t_step'(fttp_pkg::GLYPH_BYTES))) begin
            r_font_rd <= r_font_mem[fttp_pkg::t_font_addr'(r_base + fttp_pkg::t_base'(r_step))];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fr_we) begin
            r_frame_mem[w_fr_addr] <= w_fr_wdata;
        end
        if (i_cmd.pull_rd) begin
            r_frame_rd <= r_frame_mem[w_fr_addr];
        end
    end

    assign w_adv_sum = {1'b0, r_cur} + {1'b0, r_font_rd};
    assign w_adv     = w_adv_sum[8] ? 8'hFF : w_adv_sum[7:0];

    assign w_pos_end  = (r_fl_pos == fttp_pkg::t_pos'(fttp_pkg::COLUMNS + 2));
    assign w_fl_last  = w_pos_end && (r_fl_page == 2'(fttp_pkg::PAGES - 1));
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        w_pull_data = 1'b0;
        case (r_fl_pos)
            fttp_pkg::t_pos'(0): w_pull_byte = fttp_pkg::CMD_COL_LO;
            fttp_pkg::t_pos'(1): w_pull_byte = fttp_pkg::CMD_COL_HI;
            fttp_pkg::t_pos'(2): w_pull_byte = fttp_pkg::CMD_PAGE + {6'd0, r_fl_page};
            default: begin
                w_pull_byte = r_frame_rd;
                w_pull_data = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.render_setup) begin
            r_cur      <= w_top ? r_top_cur : r_bot_cur;
            r_line_bot <= !w_top;
            r_base     <= w_base;
        end
        if (i_cmd.pull_out) begin
            r_out_byte    <= w_pull_byte;
            r_out_is_data <= w_pull_data;
            r_out_last    <= w_fl_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_cur   <= 8'd0;
            r_bot_cur   <= 8'd0;
            r_step      <= '0;
            r_clr_addr  <= '0;
            r_fl_page   <= 2'd0;
            r_fl_pos    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.pull_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.render_setup) begin
                r_step <= '0;
            end else if (i_cmd.render_step) begin
                r_step <= r_step + fttp_pkg::t_step'(1);
            end
            if (i_cmd.clear_start) begin
                r_top_cur  <= 8'd0;
                r_bot_cur  <= 8'd0;
                r_fl_page  <= 2'd0;
                r_fl_pos   <= '0;
                r_clr_addr <= '0;
            end else begin
                if (i_cmd.render_step && (r_step == fttp_pkg::t_step'(1))) begin
                    if (r_line_bot) begin
                        r_bot_cur <= w_adv;
                    end else begin
                        r_top_cur <= w_adv;
                    end
                end
                if (i_cmd.clear_step) begin
                    r_clr_addr <= r_clr_addr + fttp_pkg::t_frame_addr'(1);
                end
                if (i_cmd.pull_out) begin
                    if (w_pos_end) begin
                        r_fl_pos  <= '0;
                        r_fl_page <= r_fl_page + 2'd1;
                    end else begin
                        r_fl_pos <= r_fl_pos + fttp_pkg::t_pos'(1);
                    end
                end
            end
        end
    end

    assign o_sts.glyph_ok    = w_glyph_ok;
    assign o_sts.render_done = (r_step == fttp_pkg::t_step'(fttp_pkg::GLYPH_BYTES));
    assign o_sts.clear_done  = (r_clr_addr == fttp_pkg::t_frame_addr'(fttp_pkg::FRAME_BYTES - 1));
    assign o_sts.fl_last     = w_fl_last;
    assign o_sts.out_free    = w_out_free;

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_is_data    = r_out_is_data;
    assign o_frame_last = r_out_last;

endmodule

// ===== src/font_text_to_page_framebuffer.sv =====
// ----------------------------------------------------------------------------
// Font text to page framebuffer
// Renders bitmap font glyphs into a two-line, four-page frame and streams the
// frame to the display as command and data bytes.
//
//   Channel   Direction  Handshake               Payload
//   input     in         i_in_valid/o_in_stall   i_kind, i_font_addr,
//                                                i_font_byte, i_char_code
//   output    out        o_out_valid/i_out_stall o_out_byte, o_is_data,
//                                                o_frame_last
//
// A font write is taken without stalling the input; a pull reads the frame
// store, then loads the output register. A character runs one glyph byte a
// cycle through the font store. After reset, a clear and a flush's last byte,
// a clearing pass zeroes the 512-byte frame store while input is stalled.
// A pull holds the input stalled until the previous byte has left the output.
// ----------------------------------------------------------------------------
`include "font_text_to_page_framebuffer_defines.svh"

module font_text_to_page_framebuffer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [11:0] i_font_addr,
    input  logic [7:0]  i_font_byte,
    input  logic [7:0]  i_char_code,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_is_data,
    output logic        o_frame_last
);

    fttp_pkg::t_cmd s_cmd;
    fttp_pkg::t_sts s_sts;

    fttp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .o_in_stall (o_in_stall),
        .i_sts      (s_sts),
        .o_cmd      (s_cmd)
    );

    fttp_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (s_cmd),
        .o_sts        (s_sts),
        .i_font_addr  (i_font_addr),
        .i_font_byte  (i_font_byte),
        .i_char_code  (i_char_code),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_byte   (o_out_byte),
        .o_is_data    (o_is_data),
        .o_frame_last (o_frame_last)
    );

    `FTTP_ASSERT_SAME(a_no_overwrite, s_cmd.pull_out, !o_out_valid || !i_out_stall)
    `FTTP_ASSERT_SAME(a_stall_in_clear, s_cmd.clear_step, o_in_stall)
    `FTTP_ASSERT_SAME(a_last_is_data, o_out_valid && o_frame_last, o_is_data)
    `FTTP_ASSERT_NEXT(a_flush_end_clears, s_cmd.pull_out && s_sts.fl_last, o_in_stall)

endmodule
